FILE: hdl/tkcsc_pkg.sv
// Package for the two-key clock setting controller.
// Holds the press phase, key and mode codes, register map and wrap and clamp helpers.
// No dependencies.
package tkcsc_pkg;

	// field limits of the running clock
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINUTE_MAX = 6'd59;

	// register reset values
	localparam logic [7:0] DEBOUNCE_RESET   = 8'd5;
	localparam logic [9:0] LONG_PRESS_RESET = 10'd500;

	// register map, byte addresses
	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE   = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_LONG_PRESS = 3'd4;

	// stream widths
	localparam int unsigned IN_W  = 16;
	localparam int unsigned OUT_W = 16;

	// key press sequencer
	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_DEBOUNCE = 4'b0010,
		PH_HOLD     = 4'b0100,
		PH_RELEASE  = 4'b1000
	} phase_t;

	// key that was sampled after debounce
	typedef enum logic [1:0] {
		KEY_NONE  = 2'd0,
		KEY_MODE  = 2'd1,
		KEY_ENTER = 2'd2
	} key_t;

	// operating mode, as shown on the result stream
	typedef enum logic [1:0] {
		MODE_DISPLAY = 2'd0,
		MODE_SET     = 2'd1,
		MODE_ALT     = 2'd2
	} mode_t;

	// step up with wrap to zero past the top
	function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] top);
		logic [5:0] r;
		r = (v >= top) ? 6'd0 : v + 6'd1;
		return r;
	endfunction

	// step down with wrap to the top below zero
	function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] top);
		logic [5:0] r;
		r = (v == 6'd0 || v > top) ? top : v - 6'd1;
		return r;
	endfunction

	// clamp an out-of-range clock value to its top
	function automatic logic [5:0] clamp_top(input logic [5:0] v, input logic [5:0] top);
		logic [5:0] r;
		r = (v > top) ? top : v;
		return r;
	endfunction

endpackage

FILE: hdl/two_key_clock_setting_controller_unit.sv
// Two-key clock setting controller: debounce, short/long press decode, edit of hour/minute.
// Top level with input register, press sequencer, edit registers and output register.
// Depends on tkcsc_pkg.
//
// channel   | dir | handshake               | payload
// ----------+-----+-------------------------+-------------------------------------------
// s_*       | in  | s_tvalid / s_tready     | s_tdata: key levels, clock hour and minute
// m_*       | out | m_tvalid / m_tready     | m_tdata: mode, edit values, field, flags
// apb       | in  | psel / penable / pready | debounce_ticks @0x0, long_press_ticks @0x4
//
// One request per cycle while the output side is not stalled; a result passes the input
// register, then the output register, the state update sitting between them.
// arst_n clears the sequencer, mode, field, edit values and both valid flags, and
// loads the timing registers with 5 and 500.
// A stall on m_tready backs up through the input register; s_tready drops only
// when both registers hold a request.
module two_key_clock_setting_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] key_mode_down, [1] key_enter_down, [6:2] clock_hour, [12:7] clock_minute
	input  logic [tkcsc_pkg::IN_W-1:0]    s_tdata,
	// master stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [1:0] mode, [6:2] edit_hour, [12:7] edit_minute, [13] edit_field,
	// [14] awaiting_release, [15] commit
	output logic [tkcsc_pkg::OUT_W-1:0]   m_tdata,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tkcsc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// configuration registers
	logic [7:0] debounce_q;
	logic [9:0] long_press_q;
	logic       cfg_wr;

	// input register
	logic                       valid_s1;
	logic [tkcsc_pkg::IN_W-1:0] data_s1;
	logic                       advance;

	// block state
	tkcsc_pkg::phase_t phase_q, phase_n;
	tkcsc_pkg::key_t   key_q, key_n;
	tkcsc_pkg::mode_t  mode_q, mode_n;
	logic [9:0]        wait_q, wait_n;
	logic              field_q, field_n;
	logic [4:0]        hour_q, hour_n;
	logic [5:0]        minute_q, minute_n;
	logic              commit_n;

	// unpacked request fields
	logic       k1, k2, held;
	logic [4:0] ch;
	logic [5:0] cm;

	// output register
	logic                        valid_q;
	logic [tkcsc_pkg::OUT_W-1:0] result_q;

	// configuration write and read
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= tkcsc_pkg::DEBOUNCE_RESET;
			long_press_q <= tkcsc_pkg::LONG_PRESS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr)
				tkcsc_pkg::ADDR_DEBOUNCE:   debounce_q   <= pwdata[7:0];
				tkcsc_pkg::ADDR_LONG_PRESS: long_press_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			tkcsc_pkg::ADDR_DEBOUNCE:   prdata = {24'd0, debounce_q};
			tkcsc_pkg::ADDR_LONG_PRESS: prdata = {22'd0, long_press_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// pipeline handshake
	assign advance  = valid_s1 & (~valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

	// field unpack
	assign k1   = data_s1[0];
	assign k2   = data_s1[1];
	assign ch   = data_s1[6:2];
	assign cm   = data_s1[12:7];
	assign held = (key_q == tkcsc_pkg::KEY_MODE) ? k1 : k2;

	// tick update: clock tracking, then press sequencer and action
	always_comb begin
		phase_n  = phase_q;
		key_n    = key_q;
		mode_n   = mode_q;
		wait_n   = wait_q;
		field_n  = field_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		commit_n = 1'b0;

		// edit values follow the clock in display mode
		if (mode_q == tkcsc_pkg::MODE_DISPLAY) begin
			hour_n   = 5'(tkcsc_pkg::clamp_top({1'b0, ch}, {1'b0, tkcsc_pkg::HOUR_MAX}));
			minute_n = tkcsc_pkg::clamp_top(cm, tkcsc_pkg::MINUTE_MAX);
		end

		unique case (phase_q)
			tkcsc_pkg::PH_IDLE: begin
				if (k1 || k2) begin
					phase_n = tkcsc_pkg::PH_DEBOUNCE;
					wait_n  = {2'd0, debounce_q};
				end
			end
			tkcsc_pkg::PH_DEBOUNCE: begin
				if (wait_q > 10'd1) begin
					wait_n = wait_q - 10'd1;
				end else if (k1 && !k2) begin
					key_n   = tkcsc_pkg::KEY_MODE;
					phase_n = tkcsc_pkg::PH_HOLD;
					wait_n  = long_press_q;
				end else if (k2 && !k1) begin
					key_n   = tkcsc_pkg::KEY_ENTER;
					phase_n = tkcsc_pkg::PH_HOLD;
					wait_n  = long_press_q;
				end else begin
					// both keys or none: skip to release wait
					key_n   = tkcsc_pkg::KEY_NONE;
					wait_n  = 10'd0;
					phase_n = tkcsc_pkg::PH_RELEASE;
				end
			end
			tkcsc_pkg::PH_HOLD: begin
				if (wait_q > 10'd1) begin
					wait_n = wait_q - 10'd1;
				end else begin
					key_n   = tkcsc_pkg::KEY_NONE;
					wait_n  = 10'd0;
					phase_n = tkcsc_pkg::PH_RELEASE;
					// judged press acts on mode, field and edit values
					if (key_q == tkcsc_pkg::KEY_MODE) begin
						if (held) begin
							if (mode_q == tkcsc_pkg::MODE_SET) begin
								mode_n   = tkcsc_pkg::MODE_DISPLAY;
								commit_n = 1'b1;
							end else begin
								mode_n = tkcsc_pkg::MODE_SET;
							end
						end else if (mode_q == tkcsc_pkg::MODE_SET) begin
							if (!field_q) begin
								hour_n = 5'(tkcsc_pkg::wrap_up({1'b0, hour_n},
									{1'b0, tkcsc_pkg::HOUR_MAX}));
							end else begin
								minute_n = tkcsc_pkg::wrap_up(minute_n, tkcsc_pkg::MINUTE_MAX);
							end
						end
					end else if (key_q == tkcsc_pkg::KEY_ENTER) begin
						if (held) begin
							if (mode_q == tkcsc_pkg::MODE_SET) begin
								field_n = ~field_q;
							end else if (mode_q == tkcsc_pkg::MODE_DISPLAY) begin
								mode_n = tkcsc_pkg::MODE_ALT;
							end else begin
								mode_n = tkcsc_pkg::MODE_DISPLAY;
							end
						end else if (mode_q == tkcsc_pkg::MODE_SET) begin
							if (!field_q) begin
								hour_n = 5'(tkcsc_pkg::wrap_down({1'b0, hour_n},
									{1'b0, tkcsc_pkg::HOUR_MAX}));
							end else begin
								minute_n = tkcsc_pkg::wrap_down(minute_n, tkcsc_pkg::MINUTE_MAX);
							end
						end
					end
				end
			end
			tkcsc_pkg::PH_RELEASE: begin
				if (!k1 && !k2) begin
					phase_n = tkcsc_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_n = tkcsc_pkg::PH_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tkcsc_pkg::PH_IDLE;
			key_q    <= tkcsc_pkg::KEY_NONE;
			mode_q   <= tkcsc_pkg::MODE_DISPLAY;
			wait_q   <= 10'd0;
			field_q  <= 1'b0;
			hour_q   <= 5'd0;
			minute_q <= 6'd0;
		end else if (advance) begin
			phase_q  <= phase_n;
			key_q    <= key_n;
			mode_q   <= mode_n;
			wait_q   <= wait_n;
			field_q  <= field_n;
			hour_q   <= hour_n;
			minute_q <= minute_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= {commit_n, phase_n == tkcsc_pkg::PH_RELEASE, field_n,
				minute_n, hour_n, mode_n};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = result_q;

	// checks
	a_commit_leaves_set: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> m_tdata[1:0] == tkcsc_pkg::MODE_DISPLAY)
		else $error("commit shown outside display mode");

	a_release_flag: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tdata[14] == (phase_q == tkcsc_pkg::PH_RELEASE))
		else $error("awaiting_release does not match sequencer");

	a_idle_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tkcsc_pkg::PH_IDLE |-> key_q == tkcsc_pkg::KEY_NONE)
		else $error("key latched while idle");

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:2] <= tkcsc_pkg::HOUR_MAX && m_tdata[12:7] <= tkcsc_pkg::MINUTE_MAX)
		else $error("edit value out of range");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule

FILE: test/tb_two_key_clock_setting_controller_unit.sv
// Testbench for the two-key clock setting controller: drives tick requests on the slave stream,
// predicts every result with its own copy of the press sequencer and checks the master stream.
// Depends on tkcsc_pkg and two_key_clock_setting_controller_unit.
`timescale 1ns / 100ps

module tb_two_key_clock_setting_controller_unit;

	// idling schemes for the two stream sides
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 80;

	// one tick request and one result, unpacked
	typedef struct packed {
		logic       mode_down;
		logic       enter_down;
		logic [4:0] hour;
		logic [5:0] minute;
	} tick_t;

	typedef struct packed {
		tkcsc_pkg::mode_t mode;
		logic [4:0]       hour;
		logic [5:0]       minute;
		logic             field;
		logic             awaiting;
		logic             commit;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [tkcsc_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [tkcsc_pkg::OUT_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [tkcsc_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	two_key_clock_setting_controller_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tick_t   tick_q[$];
	result_t want_q[$];
	tick_t   on_offer;
	int      idle_mode = IDLE_NONE;
	logic    long_hold_req = 1'b0;
	logic    hold_taken = 1'b0;
	int      hold_left = 0;
	int      quiet = 0;
	int      fail_count = 0;
	int      pushed = 0;
	bit      pin_clock = 1'b0;

	// predicted block state and timing registers
	tkcsc_pkg::phase_t st_phase = tkcsc_pkg::PH_IDLE;
	logic [9:0]        st_wait = '0;
	tkcsc_pkg::key_t   st_key = tkcsc_pkg::KEY_NONE;
	tkcsc_pkg::mode_t  st_mode = tkcsc_pkg::MODE_DISPLAY;
	logic              st_field = 1'b0;
	logic [4:0]        st_hour = '0;
	logic [5:0]        st_min = '0;
	logic [7:0]        cfg_debounce = tkcsc_pkg::DEBOUNCE_RESET;
	logic [9:0]        cfg_long = tkcsc_pkg::LONG_PRESS_RESET;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// step the selected edit field up or down, wrapping at the ends
	function automatic void step_edit(input bit up);
		if (st_field == 1'b0) begin
			if (up)
				st_hour = (st_hour >= tkcsc_pkg::HOUR_MAX) ? 5'd0 : st_hour + 5'd1;
			else
				st_hour = (st_hour == 5'd0 || st_hour > tkcsc_pkg::HOUR_MAX) ?
					tkcsc_pkg::HOUR_MAX : st_hour - 5'd1;
		end else begin
			if (up)
				st_min = (st_min >= tkcsc_pkg::MINUTE_MAX) ? 6'd0 : st_min + 6'd1;
			else
				st_min = (st_min == 6'd0 || st_min > tkcsc_pkg::MINUTE_MAX) ?
					tkcsc_pkg::MINUTE_MAX : st_min - 6'd1;
		end
	endfunction

	// advance the sequencer by one tick and return the result it shows
	function automatic result_t predict_tick(input tick_t t);
		result_t r;
		logic held;
		r.commit = 1'b0;
		// edit values follow the running clock while displaying
		if (st_mode == tkcsc_pkg::MODE_DISPLAY) begin
			st_hour = (t.hour > tkcsc_pkg::HOUR_MAX) ? tkcsc_pkg::HOUR_MAX : t.hour;
			st_min = (t.minute > tkcsc_pkg::MINUTE_MAX) ? tkcsc_pkg::MINUTE_MAX : t.minute;
		end
		case (st_phase)
			tkcsc_pkg::PH_IDLE: begin
				if (t.mode_down || t.enter_down) begin
					st_phase = tkcsc_pkg::PH_DEBOUNCE;
					st_wait = {2'b00, cfg_debounce};
				end
			end
			tkcsc_pkg::PH_DEBOUNCE: begin
				if (st_wait > 10'd1) begin
					st_wait = st_wait - 10'd1;
				end else if (t.mode_down && !t.enter_down) begin
					st_key = tkcsc_pkg::KEY_MODE;
					st_phase = tkcsc_pkg::PH_HOLD;
					st_wait = cfg_long;
				end else if (t.enter_down && !t.mode_down) begin
					st_key = tkcsc_pkg::KEY_ENTER;
					st_phase = tkcsc_pkg::PH_HOLD;
					st_wait = cfg_long;
				end else begin
					// both keys or none at sampling: straight to release wait
					st_key = tkcsc_pkg::KEY_NONE;
					st_wait = '0;
					st_phase = tkcsc_pkg::PH_RELEASE;
				end
			end
			tkcsc_pkg::PH_HOLD: begin
				if (st_wait > 10'd1) begin
					st_wait = st_wait - 10'd1;
				end else begin
					held = (st_key == tkcsc_pkg::KEY_MODE) ? t.mode_down : t.enter_down;
					if (st_key == tkcsc_pkg::KEY_MODE) begin
						if (held) begin
							if (st_mode == tkcsc_pkg::MODE_SET) begin
								st_mode = tkcsc_pkg::MODE_DISPLAY;
								r.commit = 1'b1;
							end else begin
								st_mode = tkcsc_pkg::MODE_SET;
							end
						end else if (st_mode == tkcsc_pkg::MODE_SET) begin
							step_edit(1'b1);
						end
					end else if (st_key == tkcsc_pkg::KEY_ENTER) begin
						if (held) begin
							if (st_mode == tkcsc_pkg::MODE_SET)
								st_field = ~st_field;
							else if (st_mode == tkcsc_pkg::MODE_DISPLAY)
								st_mode = tkcsc_pkg::MODE_ALT;
							else
								st_mode = tkcsc_pkg::MODE_DISPLAY;
						end else if (st_mode == tkcsc_pkg::MODE_SET) begin
							step_edit(1'b0);
						end
					end
					st_key = tkcsc_pkg::KEY_NONE;
					st_wait = '0;
					st_phase = tkcsc_pkg::PH_RELEASE;
				end
			end
			default: begin
				if (!t.mode_down && !t.enter_down)
					st_phase = tkcsc_pkg::PH_IDLE;
			end
		endcase
		r.mode = st_mode;
		r.hour = st_hour;
		r.minute = st_min;
		r.field = st_field;
		r.awaiting = (st_phase == tkcsc_pkg::PH_RELEASE);
		return r;
	endfunction

	// sender: offers pending ticks, predicts each accepted one
	always @(posedge clk) begin : drive
		int unsigned roll;
		bit rest;
		tick_t nxt;
		roll = $urandom_range(0, 99);
		rest = (idle_mode == IDLE_SEND && roll < 51) || (idle_mode == IDLE_BOTH && roll < 38);
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				want_q.push_back(predict_tick(on_offer));
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && !rest) begin
					nxt = tick_q.pop_front();
					on_offer = nxt;
					s_tdata <= {3'b000, nxt.minute, nxt.hour, nxt.enter_down, nxt.mode_down};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin : receive
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !((idle_mode == IDLE_RECV && roll < 51) ||
				(idle_mode == IDLE_BOTH && roll < 38));
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin : compare
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (want_q.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected, actual %h", $time, m_tdata);
			end else begin
				want = want_q.pop_front();
				check_field("mode", 32'(want.mode), 32'(m_tdata[1:0]));
				check_field("edit_hour", 32'(want.hour), 32'(m_tdata[6:2]));
				check_field("edit_minute", 32'(want.minute), 32'(m_tdata[12:7]));
				check_field("edit_field", 32'(want.field), 32'(m_tdata[13]));
				check_field("awaiting_release", 32'(want.awaiting), 32'(m_tdata[14]));
				check_field("commit", 32'(want.commit), 32'(m_tdata[15]));
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic push_tick(input logic md, input logic ed);
		tick_t t;
		t.mode_down = md;
		t.enter_down = ed;
		if (pin_clock) begin
			t.hour = tkcsc_pkg::HOUR_MAX;
			t.minute = tkcsc_pkg::MINUTE_MAX;
		end else if ($urandom_range(0, 6) == 0) begin
			// out-of-range clock now and then
			t.hour = 5'($urandom_range(0, 31));
			t.minute = 6'($urandom_range(0, 63));
		end else begin
			t.hour = 5'($urandom_range(0, 23));
			t.minute = 6'($urandom_range(0, 59));
		end
		tick_q.push_back(t);
		pushed++;
	endtask

	// one clean press; KEY_NONE stands for both keys held together
	task automatic press_seq(input tkcsc_pkg::key_t k, input bit is_long, input int gap);
		int unsigned d;
		int unsigned l;
		int unsigned len;
		d = (cfg_debounce == 0) ? 1 : cfg_debounce;
		l = (cfg_long == 0) ? 1 : cfg_long;
		// short: key up again by the judging tick, long: still down there
		len = is_long ? d + l + $urandom_range(1, 3) : d + $urandom_range(1, l);
		repeat (gap) push_tick(1'b0, 1'b0);
		repeat (len) push_tick(k == tkcsc_pkg::KEY_MODE || k == tkcsc_pkg::KEY_NONE,
			k == tkcsc_pkg::KEY_ENTER || k == tkcsc_pkg::KEY_NONE);
		push_tick(1'b0, 1'b0);
	endtask

	// mostly clean presses with random content, some key bounce
	task automatic random_run(input int n);
		int start;
		int unsigned sel;
		start = pushed;
		while (pushed - start < n) begin
			if ($urandom_range(0, 99) < 80) begin
				sel = $urandom_range(0, 9);
				press_seq((sel < 4) ? tkcsc_pkg::KEY_MODE :
					(sel < 8) ? tkcsc_pkg::KEY_ENTER : tkcsc_pkg::KEY_NONE,
					1'($urandom_range(0, 1)), $urandom_range(0, 3));
			end else begin
				repeat ($urandom_range(1, 6))
					push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic apb_xfer(input bit wr, input logic [tkcsc_pkg::ADDR_W-1:0] addr,
		input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_timing();
		logic [31:0] rd;
		apb_xfer(1'b0, tkcsc_pkg::ADDR_DEBOUNCE, 32'd0, rd);
		check_field("debounce_ticks", {24'd0, cfg_debounce}, rd);
		apb_xfer(1'b0, tkcsc_pkg::ADDR_LONG_PRESS, 32'd0, rd);
		check_field("long_press_ticks", {22'd0, cfg_long}, rd);
	endtask

	// write both timing registers with junk in the unused bits
	task automatic set_timing(input logic [7:0] d, input logic [9:0] l);
		logic [31:0] wd;
		logic [31:0] rd;
		wd = $urandom();
		wd[7:0] = d;
		apb_xfer(1'b1, tkcsc_pkg::ADDR_DEBOUNCE, wd, rd);
		cfg_debounce = d;
		wd = $urandom();
		wd[9:0] = l;
		apb_xfer(1'b1, tkcsc_pkg::ADDR_LONG_PRESS, wd, rd);
		cfg_long = l;
		check_timing();
	endtask

	// wait until every request has come back, then let the pipeline empty
	task automatic settle();
		while (tick_q.size() != 0 || s_tvalid || want_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_timing();

		// clock tracking at the extremes and clamping
		push_tick(1'b0, 1'b0);
		pin_clock = 1'b1;
		push_tick(1'b0, 1'b0);
		pin_clock = 1'b0;
		tick_q.push_back(tick_t'{mode_down: 1'b0, enter_down: 1'b0, hour: 5'd0, minute: 6'd0});
		tick_q.push_back(tick_t'{mode_down: 1'b0, enter_down: 1'b0, hour: 5'd31,
			minute: 6'd63});
		tick_q.push_back(tick_t'{mode_down: 1'b0, enter_down: 1'b0, hour: 5'd24,
			minute: 6'd60});
		settle();

		// both keys together, then every action but a long enter in alternate mode, with the
		// shortest timing, wrapping at both ends
		set_timing(8'd1, 10'd1);
		press_seq(tkcsc_pkg::KEY_NONE, 1'b1, 0);
		pin_clock = 1'b1;
		press_seq(tkcsc_pkg::KEY_MODE, 1'b1, 0);
		press_seq(tkcsc_pkg::KEY_MODE, 1'b0, 0);
		press_seq(tkcsc_pkg::KEY_ENTER, 1'b0, 0);
		press_seq(tkcsc_pkg::KEY_ENTER, 1'b1, 0);
		press_seq(tkcsc_pkg::KEY_MODE, 1'b0, 0);
		press_seq(tkcsc_pkg::KEY_ENTER, 1'b0, 0);
		press_seq(tkcsc_pkg::KEY_MODE, 1'b1, 0);
		press_seq(tkcsc_pkg::KEY_ENTER, 1'b1, 0);
		press_seq(tkcsc_pkg::KEY_MODE, 1'b1, 0);
		press_seq(tkcsc_pkg::KEY_MODE, 1'b1, 0);
		pin_clock = 1'b0;
		settle();

		// no idling, with one long receiver hold-off
		set_timing(8'd1, 10'd2);
		idle_mode <= IDLE_NONE;
		random_run(85);
		long_hold_req <= 1'b1;
		settle();

		// zero timing acts as one
		set_timing(8'd0, 10'd0);
		idle_mode <= IDLE_SEND;
		random_run(85);
		settle();

		set_timing(8'd3, 10'd5);
		idle_mode <= IDLE_RECV;
		random_run(85);
		settle();

		set_timing(8'd2, 10'd1);
		idle_mode <= IDLE_BOTH;
		random_run(85);
		settle();

		// full-range register values, then one long press at the longest debounce
		set_timing(8'd255, 10'd1023);
		set_timing(8'd255, 10'd2);
		idle_mode <= IDLE_NONE;
		press_seq(tkcsc_pkg::KEY_MODE, 1'b1, 2);
		settle();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
